[sv/m4asm_pkg.sv]
// Package for the 4x4 fixed-point matrix add/subtract/multiply core.
// Holds the element format, the command codes and the transfer payload types.
// No dependencies.
`default_nettype none

package m4asm_pkg;

  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
  // bit that selects multiply; the unused code shares it
  localparam int CMD_MUL_BIT = 1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_element;
    logic signed [ELEM_W-1:0] b_element;
    logic [CMD_W-1:0]         command;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] result_element;
    logic                     result_last;
  } out_item_t;

endpackage

`default_nettype wire

[sv/matrix4_add_sub_mul_core.sv]
// Top level of the 4x4 fixed-point matrix add/subtract/multiply core.
// Two 16-entry element memories, a read/multiply/accumulate pipeline, one output register.
// Depends on m4asm_pkg.
`default_nettype none

// Loads two 4x4 signed Q16.16 matrices, one column-major element pair per
// transfer, at one transfer per cycle. The sixteenth transfer picks the
// operation (add, subtract, multiply) and the core then emits the 16 result
// elements in column-major order, flagging the last; input is stalled while
// results are computed. One result element is in flight at a time: add and
// subtract read one element pair, multiply makes four reads through the
// single read port of each element memory into one 32x32 multiplier and one
// accumulator; each result then passes through the output register, and a
// held output delays the next element.
// The next load may start while the last results drain.
module matrix4_add_sub_mul_core
  import m4asm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  localparam int IDX_W  = 4;
  localparam int K_W    = 2;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [ACC_W-1:0] v);
    logic signed [ELEM_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[ELEM_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[ELEM_W-1:0];
    end else begin
      r = v[ELEM_W-1:0];
    end
    return r;
  endfunction

  // element memories
  logic signed [ELEM_W-1:0] left_mem  [16];
  logic signed [ELEM_W-1:0] right_mem [16];

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic               iss_act_r, iss_act_nxt;
  logic               busy_r, busy_nxt;

  logic               s1_vld_r, s1_first_r, s1_lastk_r, s1_elast_r;
  logic signed [ELEM_W-1:0] a_q_r, b_q_r;
  logic               s2_vld_r, s2_first_r, s2_lastk_r, s2_elast_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic               fin_vld_r, fin_last_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               in_xfer, out_xfer, start, is_mul, is_sub, lastk;
  logic [IDX_W-1:0]   a_addr, b_addr;
  logic signed [ACC_W-1:0]  acc_in, acc_sh;

  assign is_mul   = cmd_r[CMD_MUL_BIT];
  assign is_sub   = (cmd_r == CMD_SUB);
  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign start    = (state_r == ST_CALC) && !busy_r && !out_valid_r;
  assign lastk    = !is_mul || (k_r == K_W'(3));

  assign a_addr = is_mul ? {k_r, n_r[1:0]} : n_r;
  assign b_addr = is_mul ? {n_r[3:2], k_r} : n_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    cmd_nxt      = cmd_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    iss_act_nxt  = iss_act_r;
    busy_nxt     = busy_r;
    if (in_xfer) begin
      load_cnt_nxt = load_cnt_r + IDX_W'(1);
      if (load_cnt_r == IDX_W'(15)) begin
        cmd_nxt   = in_data.command;
        state_nxt = ST_CALC;
        n_nxt     = '0;
      end
    end
    if (start) begin
      iss_act_nxt = 1'b1;
      busy_nxt    = 1'b1;
      k_nxt       = '0;
    end
    if (iss_act_r) begin
      k_nxt = k_r + K_W'(1);
      if (lastk) begin
        iss_act_nxt = 1'b0;
        n_nxt       = n_r + IDX_W'(1);
        if (n_r == IDX_W'(15)) begin
          state_nxt = ST_LOAD;
        end
      end
    end
    if (fin_vld_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      iss_act_r  <= 1'b0;
      busy_r     <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      fin_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      iss_act_r  <= iss_act_nxt;
      busy_r     <= busy_nxt;
      s1_vld_r   <= iss_act_r;
      s2_vld_r   <= s1_vld_r;
      fin_vld_r  <= s2_vld_r && s2_lastk_r;
      if (fin_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    n_r   <= n_nxt;
    k_r   <= k_nxt;
  end

  // memories: write on load transfer, registered read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_mem[load_cnt_r]  <= in_data.a_element;
      right_mem[load_cnt_r] <= in_data.b_element;
    end
    a_q_r <= left_mem[a_addr];
    b_q_r <= right_mem[b_addr];
  end

  // datapath
  assign acc_in = (s2_first_r ? '0 : acc_r) + ACC_W'(prod_r);
  assign acc_sh = is_mul ? (acc_r >>> FRAC_W) : acc_r;

  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_lastk_r <= lastk;
    s1_elast_r <= (n_r == IDX_W'(15));
    s2_first_r <= s1_first_r;
    s2_lastk_r <= s1_lastk_r;
    s2_elast_r <= s1_elast_r;
    if (is_mul) begin
      prod_r <= PROD_W'(a_q_r) * PROD_W'(b_q_r);
    end else if (is_sub) begin
      prod_r <= PROD_W'(a_q_r) - PROD_W'(b_q_r);
    end else begin
      prod_r <= PROD_W'(a_q_r) + PROD_W'(b_q_r);
    end
    if (s2_vld_r) begin
      acc_r      <= acc_in;
      fin_last_r <= s2_elast_r;
    end
    if (fin_vld_r) begin
      out_data_r.result_element <= sat_elem(acc_sh);
      out_data_r.result_last    <= fin_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a finished element only lands in an empty output register
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld_r |-> !out_valid_r)
    else $error("result finished while output register occupied");

  a_iss_busy: assert property (@(posedge clk) disable iff (!rst_n)
    iss_act_r |-> busy_r)
    else $error("read issue outside an element in flight");

  a_calc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_CALC) |-> (load_cnt_r == '0) && !iss_act_r)
    else $error("compute entered with partial load or reads pending");

endmodule

`default_nettype wire
